FILE: hdl/dbe_pkg.sv
// shared types and constants for the delimiter backslash escaper
`default_nettype none
package dbe_pkg;

  localparam int DATA_W     = 8;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 1;
  localparam int LEN_W      = 4;

  localparam logic [DATA_W-1:0]    ESC_BYTE        = 8'h5C;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_BYTES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_LEN   = 1'd1;

  typedef struct packed {
    logic              shift;
    logic              load;
    logic [DATA_W-1:0] din;
  } cell_ctl_t;

endpackage : dbe_pkg
`default_nettype wire

FILE: hdl/dbe_if.sv
// valid/ready channel interfaces for input and result transactions
`default_nettype none
interface dbe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface : dbe_in_if

interface dbe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_string;
  logic       last_of_run;

  modport source (output valid, output out_byte, output end_of_string, output last_of_run,
                  input ready);
  modport sink (input valid, input out_byte, input end_of_string, input last_of_run,
                output ready);
endinterface : dbe_out_if
`default_nettype wire

FILE: hdl/delimiter_backslash_escaper_unit.sv
// top level: lookahead cell chain and drain sequencer
// an input transaction is accepted while no drain runs; its k result bytes follow one per cycle
//   while out_ch is ready; the first passes the draining flag, then the output register
// an item that only fills the window starts no drain; the next can follow at once
// the drain sequencer emits one byte per cycle while out_ch is ready; this sets the throughput
// synchronous active-low reset clears config, fill count and output valid
`default_nettype none
module delimiter_backslash_escaper_unit #(
  parameter int DELIM_MAX = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [dbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dbe_pkg::CFG_DATA_W-1:0] cfg_data,
  dbe_in_if.sink                              in_ch,
  dbe_out_if.source                           out_ch
);
  import dbe_pkg::*;

  localparam int FW = $clog2(DELIM_MAX + 1);
  localparam int IW = (DELIM_MAX > 1) ? $clog2(DELIM_MAX) : 1;

  cell_ctl_t             cell_ctl;
  logic [IW-1:0]         wr_idx;
  logic [FW-1:0]         dlen;
  logic [CFG_DATA_W-1:0] delim_bytes;
  logic [DATA_W-1:0]     cell_byte [DELIM_MAX];
  logic                  match     [DELIM_MAX+1];

  assign match[DELIM_MAX] = 1'b1;

  genvar i;
  generate
    for (i = 0; i < DELIM_MAX; i++) begin : g_cell
      logic [DATA_W-1:0] nbr;
      if (i < DELIM_MAX - 1) begin : g_mid
        assign nbr = cell_byte[i+1];
      end else begin : g_end
        assign nbr = '0;
      end
      dbe_cell u_cell (
        .clk        (clk),
        .ctl        (cell_ctl),
        .sel        (wr_idx == IW'(i)),
        .nbr_byte   (nbr),
        .delim_byte (delim_bytes[DATA_W*i +: DATA_W]),
        .cmp_en     (FW'(i) < dlen),
        .match_in   (match[i+1]),
        .cell_byte  (cell_byte[i]),
        .match_out  (match[i])
      );
    end
  endgenerate

  dbe_ctrl #(
    .DELIM_MAX (DELIM_MAX)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .head_byte   (cell_byte[0]),
    .head_match  (match[0]),
    .cell_ctl    (cell_ctl),
    .wr_idx      (wr_idx),
    .dlen        (dlen),
    .delim_bytes (delim_bytes)
  );

endmodule : delimiter_backslash_escaper_unit
`default_nettype wire

FILE: hdl/dbe_cell.sv
// one lookahead window cell: byte storage, left shift and delimiter compare
`default_nettype none
module dbe_cell (
  input  wire logic              clk,
  input  wire dbe_pkg::cell_ctl_t ctl,
  input  wire logic              sel,
  input  wire logic [7:0]        nbr_byte,
  input  wire logic [7:0]        delim_byte,
  input  wire logic              cmp_en,
  input  wire logic              match_in,
  output logic [7:0]             cell_byte,
  output logic                   match_out
);
  import dbe_pkg::*;

  logic [DATA_W-1:0] byte_r;

  always_ff @(posedge clk) begin
    if (ctl.load && sel) begin
      byte_r <= ctl.din;
    end else if (ctl.shift) begin
      byte_r <= nbr_byte;
    end
  end

  assign cell_byte = byte_r;
  assign match_out = match_in && (!cmp_en || (byte_r == delim_byte));

endmodule : dbe_cell
`default_nettype wire

FILE: hdl/dbe_ctrl.sv
// config registers, drain sequencer and output register
`default_nettype none
module dbe_ctrl #(
  parameter int DELIM_MAX = 8,
  localparam int FW = $clog2(DELIM_MAX + 1),
  localparam int IW = (DELIM_MAX > 1) ? $clog2(DELIM_MAX) : 1
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [dbe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [dbe_pkg::CFG_DATA_W-1:0]      cfg_data,
  dbe_in_if.sink                                   in_ch,
  dbe_out_if.source                                out_ch,
  input  wire logic [7:0]                          head_byte,
  input  wire logic                                head_match,
  output dbe_pkg::cell_ctl_t                       cell_ctl,
  output logic [IW-1:0]                            wr_idx,
  output logic [FW-1:0]                            dlen,
  output logic [dbe_pkg::CFG_DATA_W-1:0]           delim_bytes
);
  import dbe_pkg::*;

  typedef enum logic [1:0] {PH_HEAD, PH_ESC2, PH_COPY} phase_t;

  localparam logic [FW-1:0]    MAXF    = FW'(DELIM_MAX);
  localparam logic [LEN_W-1:0] MAXL    = LEN_W'(DELIM_MAX);
  localparam logic [IW-1:0]    TOP_IDX = IW'(DELIM_MAX - 1);

  logic [CFG_DATA_W-1:0] delim_bytes_r;
  logic [LEN_W-1:0]      delim_len_r;
  logic [FW-1:0]         fill_r, fill_nxt;
  logic [FW-1:0]         copy_cnt_r, copy_cnt_nxt;
  logic                  last_r;
  logic                  draining_r, draining_nxt;
  phase_t                phase_r, phase_nxt;
  logic                  out_valid_r;
  logic [DATA_W-1:0]     out_byte_r;
  logic                  eos_r;
  logic                  lor_r;

  logic [LEN_W-1:0]  len_clip;
  logic              acc;
  logic [FW-1:0]     fill_push;
  logic              start;
  logic              emit_go;
  logic              pop;
  logic              back_to_head;
  logic [FW-1:0]     fill_dec;
  logic              cont_after;
  logic              done;
  logic [DATA_W-1:0] emit_byte;

  assign len_clip    = (delim_len_r > MAXL) ? MAXL : delim_len_r;
  assign dlen        = FW'(len_clip);
  assign delim_bytes = delim_bytes_r;

  assign in_ch.ready = !draining_r;
  assign acc         = in_ch.valid && !draining_r;
  assign fill_push   = (fill_r >= MAXF) ? MAXF : fill_r + FW'(1);
  assign wr_idx      = (fill_r >= MAXF) ? TOP_IDX : fill_r[IW-1:0];
  assign start       = (dlen == '0) || (fill_push >= dlen) || in_ch.last_byte;
  assign emit_go     = draining_r && (!out_valid_r || out_ch.ready);

  always_comb begin
    pop          = 1'b0;
    back_to_head = 1'b1;
    emit_byte    = head_byte;
    phase_nxt    = phase_r;
    copy_cnt_nxt = copy_cnt_r;
    unique case (phase_r)
      PH_HEAD: begin
        if (dlen == '0) begin
          pop = 1'b1;
        end else if (head_byte == ESC_BYTE) begin
          emit_byte = ESC_BYTE;
          phase_nxt = PH_ESC2;
        end else if ((fill_r >= dlen) && head_match) begin
          emit_byte    = ESC_BYTE;
          phase_nxt    = PH_COPY;
          copy_cnt_nxt = dlen;
        end else begin
          pop = 1'b1;
        end
      end
      PH_ESC2: begin
        emit_byte = ESC_BYTE;
        pop       = 1'b1;
        phase_nxt = PH_HEAD;
      end
      PH_COPY: begin
        pop          = 1'b1;
        copy_cnt_nxt = copy_cnt_r - FW'(1);
        back_to_head = (copy_cnt_r == FW'(1));
        if (back_to_head) begin
          phase_nxt = PH_HEAD;
        end
      end
      default: begin
        phase_nxt = PH_HEAD;
      end
    endcase
  end

  assign fill_dec   = fill_r - FW'(1);
  assign cont_after = (fill_dec != '0) && ((dlen == '0) || (fill_dec >= dlen) || last_r);
  assign done       = pop && back_to_head && !cont_after;

  always_comb begin
    fill_nxt     = fill_r;
    draining_nxt = draining_r;
    if (acc) begin
      fill_nxt     = fill_push;
      draining_nxt = start;
    end else if (emit_go) begin
      if (pop) begin
        fill_nxt = fill_dec;
      end
      if (done) begin
        draining_nxt = 1'b0;
      end
    end
  end

  assign cell_ctl.shift = emit_go && pop;
  assign cell_ctl.load  = acc;
  assign cell_ctl.din   = in_ch.data_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_bytes_r <= '0;
      delim_len_r   <= '0;
      fill_r        <= '0;
      copy_cnt_r    <= '0;
      last_r        <= 1'b0;
      draining_r    <= 1'b0;
      phase_r       <= PH_HEAD;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DELIM_BYTES: delim_bytes_r <= cfg_data;
          CFG_DELIM_LEN:   delim_len_r   <= cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
      fill_r     <= fill_nxt;
      draining_r <= draining_nxt;
      if (acc) begin
        last_r  <= in_ch.last_byte;
        phase_r <= PH_HEAD;
      end else if (emit_go) begin
        phase_r    <= phase_nxt;
        copy_cnt_r <= copy_cnt_nxt;
      end
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_byte_r <= emit_byte;
      lor_r      <= done;
      eos_r      <= done && last_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_byte      = out_byte_r;
  assign out_ch.end_of_string = eos_r;
  assign out_ch.last_of_run   = lor_r;

endmodule : dbe_ctrl
`default_nettype wire

FILE: hdl/dbe_checker.sv
// port-level checker for the escaper and its bind
`default_nettype none
module dbe_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       in_last,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       out_eos,
  input wire logic       out_lor
);

  // end of string always closes a run
  a_eos_lor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_eos |-> out_lor)
    else $error("end_of_string without last_of_run");

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_eos)
                                && $stable(out_lor))
    else $error("stalled result changed");

  // a final byte always drains, so input stalls next cycle
  a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input ready after final byte");

  // an input transaction does not raise the result valid straight away
  a_no_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result raised directly after input transaction");

endmodule : dbe_checker

bind delimiter_backslash_escaper_unit dbe_checker u_dbe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.last_byte),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .out_eos   (out_ch.end_of_string),
  .out_lor   (out_ch.last_of_run)
);
`default_nettype wire

FILE: tb/delimiter_backslash_escaper_unit_tb.sv
// self-checking testbench for the delimiter backslash escaper with a running prediction model
`default_nettype none
module delimiter_backslash_escaper_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dbe_pkg::*;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_string;
    logic       last_of_run;
  } esc_out_t;

  typedef logic [7:0] byte_str_t [$];

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  bit                    clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  dbe_in_if  in_ch();
  dbe_out_if out_ch();

  delimiter_backslash_escaper_unit #(.DELIM_MAX(8)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // predicted state and configuration
  logic [63:0] delim_val;
  logic [3:0]  delim_len;
  logic [7:0]  pend_win [8];
  int          pend_fill;
  esc_out_t    escaped_q [$];

  int       err_count;
  int       sent_items;
  int       burst_left;
  bit       gaps_on;
  int       hold_off;
  int       rx_cnt;
  rx_mode_t rx_mode;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic expect_byte(input logic [7:0] b);
    esc_out_t r;
    r.out_byte      = b;
    r.end_of_string = 1'b0;
    r.last_of_run   = 1'b0;
    escaped_q.push_back(r);
  endtask

  task automatic drop_pending(input int n);
    int k;
    for (k = 0; k + n < pend_fill; k++) pend_win[k] = pend_win[k + n];
    pend_fill -= n;
  endtask

  task automatic predict_escape(input logic [7:0] b, input logic lst);
    int       dl;
    int       first;
    int       k;
    bit       hit;
    esc_out_t r;
    dl = (delim_len > 4'd8) ? 8 : int'(delim_len);
    first = escaped_q.size();
    if (pend_fill >= 8) pend_fill = 7;
    pend_win[pend_fill] = b;
    pend_fill++;
    while (pend_fill > 0 && (dl == 0 || pend_fill >= dl || lst)) begin
      hit = (dl > 0 && pend_fill >= dl);
      for (k = 0; k < dl && hit; k++) if (pend_win[k] != delim_val[8*k +: 8]) hit = 1'b0;
      if (dl == 0) begin
        expect_byte(pend_win[0]);
        drop_pending(1);
      end else if (pend_win[0] == ESC_BYTE) begin
        expect_byte(ESC_BYTE);
        expect_byte(ESC_BYTE);
        drop_pending(1);
      end else if (hit) begin
        expect_byte(ESC_BYTE);
        for (k = 0; k < dl; k++) expect_byte(pend_win[k]);
        drop_pending(dl);
      end else begin
        expect_byte(pend_win[0]);
        drop_pending(1);
      end
    end
    if (escaped_q.size() > first) begin
      r = escaped_q.pop_back();
      r.last_of_run = 1'b1;
      if (lst) r.end_of_string = 1'b1;
      escaped_q.push_back(r);
    end
    if (lst) pend_fill = 0;
  endtask

  // result checking
  always @(posedge clk) begin : check_out
    esc_out_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (escaped_q.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual byte %02h eos %0b run %0b",
                 $time, out_ch.out_byte, out_ch.end_of_string, out_ch.last_of_run);
        err_count++;
      end else begin
        want = escaped_q.pop_front();
        if (out_ch.out_byte !== want.out_byte) begin
          $display("%0t: out_byte expected %02h actual %02h",
                   $time, want.out_byte, out_ch.out_byte);
          err_count++;
        end
        if (out_ch.end_of_string !== want.end_of_string) begin
          $display("%0t: end_of_string expected %0b actual %0b",
                   $time, want.end_of_string, out_ch.end_of_string);
          err_count++;
        end
        if (out_ch.last_of_run !== want.last_of_run) begin
          $display("%0t: last_of_run expected %0b actual %0b",
                   $time, want.last_of_run, out_ch.last_of_run);
          err_count++;
        end
      end
    end
  end

  // receiver stall pattern, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_ch.ready <= 1'b0;
      hold_off--;
    end else begin
      if (rx_cnt % 48 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
      case (rx_mode)
        RX_OPEN:   out_ch.ready <= 1'b1;
        RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default:   out_ch.ready <= (rx_cnt % 3 != 0);
      endcase
      rx_cnt++;
    end
  end

  task automatic send_item(input logic [7:0] b, input logic lst);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = gaps_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_escape(b, lst);
    sent_items++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic send_bytes(input byte_str_t s, input bit term);
    foreach (s[i]) send_item(s[i], term && (i == s.size() - 1));
  endtask

  task automatic send_text(input string t, input bit term);
    int i;
    for (i = 0; i < t.len(); i++) send_item(t[i], term && (i == t.len() - 1));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (escaped_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_delimiter(input logic [63:0] bytes_v, input logic [3:0] len_v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DELIM_BYTES;
    cfg_data  <= bytes_v;
    @(negedge clk);
    cfg_index <= CFG_DELIM_LEN;
    cfg_data  <= {{(CFG_DATA_W-4){1'b0}}, len_v};
    @(negedge clk);
    cfg_we    <= 1'b0;
    delim_val = bytes_v;
    delim_len = len_v;
  endtask

  task automatic pick_delimiter();
    logic [63:0] bv;
    logic [3:0]  len;
    int          k;
    bv = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: bv = {8{bv[7:0]}};
      1: begin
        k = $urandom_range(0, 7);
        bv[8*k +: 8] = ESC_BYTE;
      end
      2: for (k = 0; k < 8; k++) bv[8*k +: 8] = 8'h61 + 8'($urandom_range(0, 1));
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0:       len = 4'd0;
      1:       len = 4'($urandom_range(9, 15));
      default: len = 4'($urandom_range(1, 8));
    endcase
    set_delimiter(bv, len);
  endtask

  function automatic byte_str_t make_string(input int max_len);
    byte_str_t s;
    int        n;
    int        dl;
    int        pick;
    int        k;
    int        cut;
    bit        noise;
    dl = (delim_len > 4'd8) ? 8 : int'(delim_len);
    n = $urandom_range(1, max_len);
    noise = ($urandom_range(0, 7) == 0);
    while (s.size() < n) begin
      pick = noise ? 9 : $urandom_range(0, 9);
      if (dl > 0 && pick < 3) begin
        for (k = 0; k < dl; k++) s.push_back(delim_val[8*k +: 8]);
      end else if (dl > 1 && pick == 3) begin
        cut = $urandom_range(1, dl - 1);
        for (k = 0; k < cut; k++) s.push_back(delim_val[8*k +: 8]);
      end else if (pick == 4) begin
        s.push_back(ESC_BYTE);
      end else if (dl > 0 && pick == 5) begin
        k = $urandom_range(0, dl - 1);
        s.push_back(delim_val[8*k +: 8]);
      end else begin
        s.push_back(8'($urandom_range(0, 255)));
      end
    end
    return s;
  endfunction

  task automatic test_passthrough();
    // reset state: zero length, nothing escaped
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(ESC_BYTE, 1'b1);
  endtask

  task automatic test_single_byte_delimiter();
    // upper delimiter bytes beyond the length are ignored
    set_delimiter(64'hFFFF_FFFF_FFFF_FF2C, 4'd1);
    send_item(8'h00, 1'b0);
    send_text(",\\", 1'b1);
  endtask

  task automatic test_full_width_delimiter();
    // length above the maximum acts as eight
    set_delimiter(64'h4847_4645_4443_4241, 4'd15);
    send_text("ABCDEFGH", 1'b1);
  endtask

  task automatic test_backslash_priority();
    set_delimiter(64'h0000_0000_0000_785C, 4'd2);
    send_text("\\x", 1'b1);
    set_delimiter(64'h0000_0000_0000_6261, 4'd2);
    send_text("a", 1'b1);
  endtask

  task automatic test_length_change();
    set_delimiter(64'h0000_0000_5A59_5857, 4'd4);
    send_text("WXY", 1'b0);
    set_delimiter(64'h0000_0000_0000_5958, 4'd2);
    send_text("Z", 1'b0);
    set_delimiter(64'h0000_0000_0000_5958, 4'd0);
    send_text("q", 1'b1);
  endtask

  task automatic test_random_strings();
    int        start;
    bit        carry;
    byte_str_t s;
    start = sent_items;
    carry = 1'b1;
    while (sent_items - start < 120) begin
      if (carry || $urandom_range(0, 5) == 0) begin
        pick_delimiter();
        gaps_on = ($urandom_range(0, 3) != 0);
      end
      s = make_string(14);
      carry = ($urandom_range(0, 9) == 0);
      send_bytes(s, !carry);
    end
    if (carry) send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic test_backpressure();
    int i;
    set_delimiter(64'h4847_4645_4443_4241, 4'd8);
    gaps_on  = 1'b0;
    hold_off = 300;
    send_text("\\\\\\\\\\\\\\\\", 1'b1);
    for (i = 0; i < 4; i++) send_text("ABCDEFGH", i == 3);
    gaps_on = 1'b1;
  endtask

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.last_byte = 1'b0;
    out_ch.ready    = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_DELIM_BYTES;
    cfg_data        = '0;
    rst_n           = 1'b0;
    delim_val       = '0;
    delim_len       = '0;
    pend_fill       = 0;
    err_count       = 0;
    sent_items      = 0;
    burst_left      = 0;
    gaps_on         = 1'b1;
    hold_off        = 0;
    rx_cnt          = 0;
    rx_mode         = RX_OPEN;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_passthrough();
    test_single_byte_delimiter();
    test_full_width_delimiter();
    test_backslash_priority();
    test_length_change();
    test_random_strings();
    test_backpressure();

    wait_drained();
    repeat (20) @(negedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule : delimiter_backslash_escaper_unit_tb
`default_nettype wire

FILE: delimiter_backslash_escaper_unit.f
hdl/dbe_pkg.sv
hdl/dbe_if.sv
hdl/dbe_cell.sv
hdl/dbe_ctrl.sv
hdl/delimiter_backslash_escaper_unit.sv
hdl/dbe_checker.sv
tb/delimiter_backslash_escaper_unit_tb.sv
